// ----- rtl/qstd_pkg.sv -----
// Shared types and constants for the smallest-three quaternion decoder.
`default_nettype none

package qstd_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int CODE_W        = 10;
    localparam int COMP_W        = 16;
    localparam int HALF_W        = 16;
    localparam int LANES         = 3;
    localparam int AXES          = 4;
    localparam int LANE_STAGES   = 3;

    localparam logic [CODE_W-1:0] CODE_MAX = 10'h3FF;

    // round(2^30/sqrt2) = 759250125 = 1023 * SCALE_Q + SCALE_R
    localparam int SCALE_Q   = 742179;
    localparam int SCALE_R   = 1008;
    localparam int SCALE_Q_W = 30;
    localparam int SCALE_R_W = 20;

    typedef struct packed {
        logic [HALF_W-1:0] packed_high;
        logic [HALF_W-1:0] packed_low;
    } t_in_item;

    typedef struct packed {
        logic signed [COMP_W-1:0] comp_x;
        logic signed [COMP_W-1:0] comp_y;
        logic signed [COMP_W-1:0] comp_z;
        logic signed [COMP_W-1:0] comp_w;
        logic                     norm_clamped;
    } t_out_item;

endpackage

`default_nettype wire

// ----- rtl/quaternion_smallest_three_decode_top.sv -----
// Top level of the smallest-three quaternion decoder.
//
// Input channel: i_valid / o_stall carry one packed 32-bit rotation word
// (i_data.packed_high, i_data.packed_low) per transaction.
// Output channel: o_valid / i_stall carry the four components in signed
// fixed point with FRAC_BITS fractional bits plus the norm_clamped flag.
//
// Throughput: one transaction per cycle, sustained while the receiver does not stall.
// Pipeline stages from accept to o_valid:
//   3 lane stages (scale, divide-by-1023 and round, sign and square),
//   1 stage for the sum of squares and clamp,
//   FRAC_BITS + 1 stages of the square-root pipeline (one root bit each),
//   1 output register where the rounded root and lanes are placed.
// Every stage has its own valid bit and advances whenever it is empty or
// the stage after it advances, so bubbles close up. While the receiver
// stalls, the output holds and new transactions are still taken until the
// pipeline is full; o_stall then follows.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers
// are not reset. There is no other state.
`default_nettype none

module quaternion_smallest_three_decode_top #(
    parameter int FRAC_BITS = qstd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire qstd_pkg::t_in_item   i_data,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output qstd_pkg::t_out_item       o_data
);
    import qstd_pkg::*;

    localparam int NS = FRAC_BITS + 6;   // total pipeline stages

    logic [NS-1:0] r_vld;
    logic [NS-1:0] stage_en;

    // a stage loads when it is empty or its successor moves on
    always_comb begin
        stage_en[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !stage_en[0];
    assign o_valid = r_vld[NS-1];

    // unpack the three codes and the largest-axis index
    logic [1:0]        largest;
    logic [CODE_W-1:0] code [LANES];

    always_comb begin
        largest = i_data.packed_high[15:14];
        code[0] = i_data.packed_high[13:4];
        code[1] = {i_data.packed_high[3:0], i_data.packed_low[15:10]};
        code[2] = i_data.packed_low[9:0];
    end

    // decode lanes, one per transmitted component
    logic signed [FRAC_BITS:0]  lane_val [LANES];
    logic [2*FRAC_BITS-1:0]     lane_sq  [LANES];

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        qstd_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (stage_en[LANE_STAGES-1:0]),
            .i_code   (code[i]),
            .o_value  (lane_val[i]),
            .o_square (lane_sq[i])
        );
    end

    // norm, root and placement
    qstd_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_en      (stage_en),
        .i_largest (largest),
        .i_value   (lane_val),
        .i_square  (lane_sq),
        .o_data    (o_data)
    );

endmodule

`default_nettype wire

// ----- rtl/qstd_lane.sv -----
// One decode lane: 10-bit code to signed fixed-point component and its square.
`default_nettype none

module qstd_lane #(
    parameter int FRAC_BITS = qstd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic [qstd_pkg::LANE_STAGES-1:0]     i_en,
    input  wire logic [qstd_pkg::CODE_W-1:0]          i_code,
    output logic signed [FRAC_BITS:0]                 o_value,
    output logic [2*FRAC_BITS-1:0]                    o_square
);
    import qstd_pkg::*;

    localparam int SHIFT = 30 - FRAC_BITS;
    localparam int SQ_W  = 2 * FRAC_BITS;

    // stage A: |2c-1023| times split scale constant
    logic [CODE_W:0]    twice;
    logic               n_neg;
    logic [CODE_W:0]    diff;
    logic [CODE_W-1:0]  mag;
    logic [SCALE_Q_W-1:0] r_prod_q;
    logic [SCALE_R_W-1:0] r_prod_r;
    logic               r_neg_a;

    always_comb begin
        twice = {i_code, 1'b0};
        n_neg = twice < {1'b0, CODE_MAX};
        diff  = n_neg ? ({1'b0, CODE_MAX} - twice) : (twice - {1'b0, CODE_MAX});
        mag   = diff[CODE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod_q <= SCALE_Q_W'(mag) * SCALE_Q_W'(SCALE_Q);
            r_prod_r <= SCALE_R_W'(mag) * SCALE_R_W'(SCALE_R);
            r_neg_a  <= n_neg;
        end
    end

    // stage B: remainder part / 1023, then round half up
    logic [CODE_W-1:0]    est;
    logic [SCALE_R_W-1:0] rem_full;
    logic [CODE_W:0]      rem;
    logic [CODE_W-1:0]    q1;
    logic [CODE_W-1:0]    r1;
    logic                 half;
    logic [SCALE_Q_W-1:0] total;
    logic [31:0]          rnd_sum;
    logic [FRAC_BITS-1:0] n_mag;
    logic [FRAC_BITS-1:0] r_mag;
    logic                 r_neg_b;

    always_comb begin
        est      = r_prod_r[SCALE_R_W-1:CODE_W];
        rem_full = r_prod_r - {est, {CODE_W{1'b0}}} + SCALE_R_W'(est);
        rem      = rem_full[CODE_W:0];
        if (rem >= {1'b0, CODE_MAX}) begin
            q1 = est + 10'd1;
            r1 = CODE_W'(rem - {1'b0, CODE_MAX});
        end else begin
            q1 = est;
            r1 = rem[CODE_W-1:0];
        end
        half    = {r1, 1'b0} >= {1'b0, CODE_MAX};
        total   = r_prod_q + SCALE_Q_W'(q1);
        rnd_sum = 32'({total, half}) + (32'd1 << SHIFT);
        n_mag   = FRAC_BITS'(rnd_sum >> (SHIFT + 1));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_mag   <= n_mag;
            r_neg_b <= r_neg_a;
        end
    end

    // stage C: sign and square
    logic signed [FRAC_BITS:0] pos_val;

    assign pos_val = $signed({1'b0, r_mag});

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            o_value  <= r_neg_b ? -pos_val : pos_val;
            o_square <= SQ_W'(r_mag) * SQ_W'(r_mag);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/qstd_root.sv -----
// Pipelined rounded integer square root, one result bit per stage.
`default_nettype none

module qstd_root #(
    parameter int FRAC_BITS = qstd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic [FRAC_BITS:0]     i_en,
    input  wire logic [2*FRAC_BITS:0]   i_radicand,
    output logic [FRAC_BITS:0]          o_root
);
    import qstd_pkg::*;

    localparam int STAGES = FRAC_BITS + 1;
    localparam int RAD_W  = 2 * STAGES;
    localparam int ROOT_W = FRAC_BITS + 1;
    localparam int REM_W  = FRAC_BITS + 4;

    logic [REM_W-1:0]  r_rem  [STAGES];
    logic [ROOT_W-1:0] r_root [STAGES];
    logic [RAD_W-1:0]  r_rad  [STAGES-1];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  cur;
        logic [REM_W-1:0]  trial;
        logic              take;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = RAD_W'(i_radicand);
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
        end

        always_comb begin
            cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
            trial = REM_W'({root_in, 2'b01});
            take  = cur >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k]  <= take ? (cur - trial) : cur;
                r_root[k] <= {root_in[ROOT_W-2:0], take};
            end
        end

        if (k < STAGES - 1) begin : g_rad
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_rad[k] <= {rad_in[RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    // round to nearest: bump when remainder exceeds floor root
    assign o_root = (r_rem[STAGES-1] > REM_W'(r_root[STAGES-1]))
                  ? r_root[STAGES-1] + ROOT_W'(1) : r_root[STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/qstd_merge.sv -----
// Merge: sum of squares, clamp, root pipeline and placement of components.
`default_nettype none

module qstd_merge #(
    parameter int FRAC_BITS = qstd_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic [FRAC_BITS+5:0]             i_en,
    input  wire logic [1:0]                       i_largest,
    input  wire logic signed [FRAC_BITS:0]        i_value  [qstd_pkg::LANES],
    input  wire logic [2*FRAC_BITS-1:0]           i_square [qstd_pkg::LANES],
    output qstd_pkg::t_out_item                   o_data
);
    import qstd_pkg::*;

    localparam int ROOT_STAGES = FRAC_BITS + 1;
    localparam int NS          = FRAC_BITS + 6;
    localparam int SUM_IDX     = LANE_STAGES;
    localparam int ROOT_IDX    = LANE_STAGES + 1;
    localparam int SUM_W       = 2 * FRAC_BITS + 2;
    localparam int RAD_W       = 2 * FRAC_BITS + 1;
    localparam int VAL_W       = FRAC_BITS + 1;
    localparam int EXT_W       = (VAL_W > COMP_W) ? VAL_W : COMP_W;

    // largest index follows the lanes
    logic [1:0] r_lane_lg [LANE_STAGES];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < LANE_STAGES; k++) begin
            if (i_en[k]) begin
                r_lane_lg[k] <= (k == 0) ? i_largest : r_lane_lg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // sum stage
    logic [SUM_W-1:0]        sum;
    logic [SUM_W-1:0]        one;
    logic                    n_clamp;
    logic [RAD_W-1:0]        n_rad;
    logic [RAD_W-1:0]        r_rad;
    logic                    r_sum_clamp;
    logic [1:0]              r_sum_lg;
    logic signed [FRAC_BITS:0] r_sum_val [LANES];

    always_comb begin
        sum     = SUM_W'(i_square[0]) + SUM_W'(i_square[1]) + SUM_W'(i_square[2]);
        one     = SUM_W'(1) << (2 * FRAC_BITS);
        n_clamp = sum > one;
        n_rad   = n_clamp ? '0 : RAD_W'(one - sum);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[SUM_IDX]) begin
            r_rad       <= n_rad;
            r_sum_clamp <= n_clamp;
            r_sum_lg    <= r_lane_lg[LANE_STAGES-1];
            r_sum_val   <= i_value;
        end
    end

    // root pipeline and matching side taps
    logic [FRAC_BITS:0] root;

    qstd_root #(
        .FRAC_BITS (FRAC_BITS)
    ) u_root (
        .i_clk      (i_clk),
        .i_en       (i_en[ROOT_IDX +: ROOT_STAGES]),
        .i_radicand (r_rad),
        .o_root     (root)
    );

    logic                      r_side_clamp [ROOT_STAGES];
    logic [1:0]                r_side_lg    [ROOT_STAGES];
    logic signed [FRAC_BITS:0] r_side_val   [ROOT_STAGES][LANES];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < ROOT_STAGES; k++) begin
            if (i_en[ROOT_IDX + k]) begin
                if (k == 0) begin
                    r_side_clamp[k] <= r_sum_clamp;
                    r_side_lg[k]    <= r_sum_lg;
                    r_side_val[k]   <= r_sum_val;
                end else begin
                    r_side_clamp[k] <= r_side_clamp[(k == 0) ? 0 : k - 1];
                    r_side_lg[k]    <= r_side_lg[(k == 0) ? 0 : k - 1];
                    r_side_val[k]   <= r_side_val[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // placement: lane i lands on axis (largest + 1 + i) mod 4
    logic [1:0]              lg;
    logic [1:0]              slot;
    logic [COMP_W-1:0]       root_f;
    logic [COMP_W-1:0]       lane_f [LANES];
    logic [EXT_W-1:0]        ext;
    logic [COMP_W-1:0]       comp [AXES];
    t_out_item               n_data;

    always_comb begin
        lg     = r_side_lg[ROOT_STAGES-1];
        ext    = EXT_W'(root);
        root_f = ext[COMP_W-1:0];
        for (int i = 0; i < LANES; i++) begin
            ext       = EXT_W'(r_side_val[ROOT_STAGES-1][i]);
            lane_f[i] = ext[COMP_W-1:0];
        end
        for (int j = 0; j < AXES; j++) begin
            slot = 2'(j) - lg - 2'd1;
            if (2'(j) == lg) begin
                comp[j] = root_f;
            end else begin
                case (slot)
                    2'd0:    comp[j] = lane_f[0];
                    2'd1:    comp[j] = lane_f[1];
                    default: comp[j] = lane_f[2];
                endcase
            end
        end
        n_data.comp_x       = comp[0];
        n_data.comp_y       = comp[1];
        n_data.comp_z       = comp[2];
        n_data.comp_w       = comp[3];
        n_data.norm_clamped = r_side_clamp[ROOT_STAGES-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[NS-1]) begin
            o_data <= n_data;
        end
    end

endmodule

`default_nettype wire

// ----- verif/quaternion_smallest_three_decode_top_tb.sv -----
// Self-checking testbench for the smallest-three quaternion decoder top level.
`default_nettype none

module quaternion_smallest_three_decode_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qstd_pkg::*;

    // Decoder parameters and run bounds.
    localparam int            FRAC_BITS     = FRAC_BITS_DEF;
    localparam int            LATENCY       = FRAC_BITS + 6;
    localparam longint unsigned ROOT_HALF_Q30 = 64'd759250125;   // round(2^30/sqrt2)
    localparam longint unsigned UNIT_SQ     = 64'd1 << (2 * FRAC_BITS);
    localparam int            CYCLE_LIMIT   = 200000;
    localparam int            HOLD_CYCLES   = 100;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} t_stall_style;

    // DUT ports. Every input has a known value from time zero.
    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_in_item   i_data  = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_out_item  o_data;

    // Quaternions predicted for accepted words, oldest first.
    t_out_item  expected_quats [$];
    t_out_item  want;
    int         fail_count = 0;
    int         cycle_cnt  = 0;

    // Sender burst control (owned by the initial block).
    int         burst_left = 0;
    bit         gaps_on    = 1'b1;

    // Receiver stall control. The test side only bumps hold_req_n and
    // changes the style and stall_pct; the stall process owns everything else.
    t_stall_style stall_style = STALL_NONE;
    int         stall_pct    = 0;
    int         hold_req_n   = 0;
    int         hold_seen    = 0;
    int         hold_left    = 0;
    logic [15:0] stall_pattern = 16'b0011_1000_0110_0001;

    quaternion_smallest_three_decode_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    // One 10-bit code to fixed point: (2c-1023)/1023 * 1/sqrt2, rounded to
    // nearest, ties away from zero (done on the magnitude).
    function automatic longint signed code_to_q(logic [9:0] code);
        int              twice_off;
        longint unsigned mag;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        twice_off = 2 * int'(code) - 1023;
        mag = (twice_off < 0) ? -twice_off : twice_off;
        num = mag * ROOT_HALF_Q30;
        den = 64'd1023 << (30 - FRAC_BITS);
        q   = (2 * num + den) / (2 * den);
        return (twice_off < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Integer square root, rounded to nearest (never lands on a half).
    function automatic longint unsigned round_root(longint unsigned v);
        longint unsigned rem;
        longint unsigned root;
        longint unsigned probe;
        rem   = v;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > rem)
            probe >>= 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  -= root + probe;
                root  = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        if (v - root * root > root)
            root++;
        return root;
    endfunction

    // Full decode of one packed rotation word.
    function automatic t_out_item decode_quat(t_in_item w);
        logic [1:0]      big_axis;
        logic [9:0]      codes [3];
        longint signed   comp [4];
        longint signed   v;
        longint unsigned sq_sum;
        longint unsigned root_in;
        t_out_item       r;
        int              i;
        big_axis = w.packed_high[15:14];
        codes[0] = w.packed_high[13:4];
        codes[1] = {w.packed_high[3:0], w.packed_low[15:10]};
        codes[2] = w.packed_low[9:0];
        sq_sum   = 0;
        for (i = 0; i < 3; i++) begin
            v = code_to_q(codes[i]);
            comp[(int'(big_axis) + 1 + i) & 3] = v;
            sq_sum += longint'(v * v);
        end
        // Sum above one: root input clamped to zero and flagged.
        r.norm_clamped = (sq_sum > UNIT_SQ);
        root_in = r.norm_clamped ? 64'd0 : UNIT_SQ - sq_sum;
        comp[big_axis] = longint'(round_root(root_in));
        r.comp_x = comp[0][15:0];
        r.comp_y = comp[1][15:0];
        r.comp_z = comp[2][15:0];
        r.comp_w = comp[3][15:0];
        return r;
    endfunction

    function automatic t_in_item pack_word(logic [1:0] axis, logic [9:0] c0,
                                           logic [9:0] c1, logic [9:0] c2);
        t_in_item w;
        w.packed_high = {axis, c0, c1[9:6]};
        w.packed_low  = {c1[5:0], c2};
        return w;
    endfunction

    // Code uniform, or biased toward the ends of the range or toward the middle,
    // where the small components are near zero and the large one near one.
    function automatic logic [9:0] pick_code(int style);
        case (style)
            1:       return $urandom_range(0, 1) ? 10'($urandom_range(0, 3))
                                                 : 10'($urandom_range(1020, 1023));
            2:       return 10'($urandom_range(500, 523));
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic t_in_item random_word();
        t_in_item w;
        if ($urandom_range(0, 9) < 6) begin
            w = t_in_item'($urandom);
        end else begin
            w = pack_word(2'($urandom_range(0, 3)),
                          pick_code($urandom_range(0, 2)),
                          pick_code($urandom_range(0, 2)),
                          pick_code($urandom_range(0, 2)));
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one word and wait for the transaction. Called right after a
    // rising edge; returns right after the accepting edge with i_valid
    // still high, so back-to-back words keep valid asserted. Between bursts
    // valid drops for a random gap when gaps_on is set.
    task automatic send_word(t_in_item w);
        if (burst_left == 0) begin
            if (gaps_on) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        expected_quats.push_back(decode_quat(w));
    endtask

    // Drop valid and wait until every outstanding quaternion is out.
    // Always waits on a clock edge first, so valid never toggles twice in a step.
    task automatic wait_all_decoded();
        i_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge i_clk);
        while (expected_quats.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: stall pattern, random stalls, or a long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        if (hold_req_n != hold_seen) begin
            hold_seen <= hold_req_n;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            case (stall_style)
                STALL_RANDOM:  i_stall <= ($urandom_range(0, 99) < stall_pct);
                STALL_PATTERN: i_stall <= stall_pattern[0];
                default:       i_stall <= 1'b0;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checking: every output transaction against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] got_v);
        if (got_v !== exp_v) begin
            fail_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_quats.size() == 0) begin
                fail_count++;
                $display("%0t: output transaction with none pending, actual %0d %0d %0d %0d %0b",
                         $time, o_data.comp_x, o_data.comp_y, o_data.comp_z,
                         o_data.comp_w, o_data.norm_clamped);
            end else begin
                want = expected_quats.pop_front();
                check_field("comp_x", want.comp_x, o_data.comp_x);
                check_field("comp_y", want.comp_y, o_data.comp_y);
                check_field("comp_z", want.comp_z, o_data.comp_z);
                check_field("comp_w", want.comp_w, o_data.comp_w);
                check_field("norm_clamped", {31'b0, want.norm_clamped},
                            {31'b0, o_data.norm_clamped});
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[quaternion_smallest_three_decode_top] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Codes at both ends and at mid-scale with every choice of largest axis,
    // plus alternating bit patterns across both halves.
    task automatic test_extreme_codes();
        int axis;
        for (axis = 0; axis < 4; axis++) begin
            send_word(pack_word(2'(axis), 10'd0, 10'd0, 10'd0));          // clamped
            send_word(pack_word(2'(axis), CODE_MAX, CODE_MAX, CODE_MAX)); // clamped
            send_word(pack_word(2'(axis), 10'd511, 10'd512, 10'd511));    // largest near one
        end
        send_word(pack_word(2'd0, 10'd0, 10'd511, 10'd512));
        send_word('{packed_high: 16'hAAAA, packed_low: 16'h5555});
        send_word('{packed_high: 16'h5555, packed_low: 16'hAAAA});
        wait_all_decoded();
    endtask

    // Sum of squares right at one. Search the code magnitudes for a triple
    // whose squares sum to exactly one (or the closest from below), and the
    // closest triple just above one.
    task automatic test_unit_norm_edge();
        longint unsigned mag_sq [512];
        longint signed   need;
        longint unsigned total;
        longint unsigned best_below;
        longint unsigned best_above;
        int              i, j, k, lo_k, hi_k, mid_k;
        int              bi, bj, bk, ai, aj, ak;
        best_below = 0;
        best_above = '1;
        bi = 0; bj = 0; bk = 0; ai = 0; aj = 0; ak = 0;
        for (i = 0; i < 512; i++)
            mag_sq[i] = longint'(code_to_q(10'(512 + i)) * code_to_q(10'(512 + i)));
        for (i = 0; i < 512; i++) begin
            for (j = i; j < 512; j++) begin
                need = longint'(UNIT_SQ) - longint'(mag_sq[i]) - longint'(mag_sq[j]);
                if (need < 0)
                    break;
                // largest k with mag_sq[k] <= need
                lo_k = -1;
                hi_k = 511;
                while (lo_k < hi_k) begin
                    mid_k = (lo_k + hi_k + 1) / 2;
                    if (longint'(mag_sq[mid_k]) <= need)
                        lo_k = mid_k;
                    else
                        hi_k = mid_k - 1;
                end
                k = lo_k;
                if (k >= 0) begin
                    total = mag_sq[i] + mag_sq[j] + mag_sq[k];
                    if (total >= best_below) begin
                        best_below = total; bi = i; bj = j; bk = k;
                    end
                end
                if (k < 511) begin
                    total = mag_sq[i] + mag_sq[j] + mag_sq[k + 1];
                    if (total < best_above) begin
                        best_above = total; ai = i; aj = j; ak = k + 1;
                    end
                end
            end
        end
        // 511-n has the same magnitude as 512+n, negative
        send_word(pack_word(2'd3, 10'(512 + bi), 10'(511 - bj), 10'(512 + bk)));
        send_word(pack_word(2'd1, 10'(511 - bi), 10'(512 + bj), 10'(511 - bk)));
        send_word(pack_word(2'd2, 10'(511 - ai), 10'(512 + aj), 10'(511 - ak)));
        wait_all_decoded();
    endtask

    // Receiver holds off for a long stretch while words keep coming back to
    // back: the pipeline fills and o_stall rises, then everything drains.
    task automatic test_full_pipeline_stall();
        int n;
        stall_style <= STALL_NONE;
        gaps_on = 1'b0;
        hold_req_n <= hold_req_n + 1;
        for (n = 0; n < 80; n++)
            send_word(random_word());
        wait_all_decoded();
    endtask

    // Random words under several idling mixes, including a stretch with no
    // idling on either side.
    task automatic test_random_words();
        int phase, n;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin stall_style <= STALL_NONE;    gaps_on = 1'b0; end
                1: begin stall_style <= STALL_RANDOM;  stall_pct <= 30; gaps_on = 1'b1; end
                2: begin stall_style <= STALL_PATTERN; gaps_on = 1'b1; end
                3: begin stall_style <= STALL_RANDOM;  stall_pct <= 70; gaps_on = 1'b1; end
                4: begin stall_style <= STALL_NONE;    gaps_on = 1'b1; end
                default: begin stall_style <= STALL_RANDOM; stall_pct <= 15; gaps_on = 1'b0; end
            endcase
            for (n = 0; n < 230; n++)
                send_word(random_word());
        end
        wait_all_decoded();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        stall_style <= STALL_RANDOM;
        stall_pct   <= 25;
        test_extreme_codes();
        test_unit_norm_edge();
        test_full_pipeline_stall();
        test_random_words();

        // Any late or extra output transaction shows up in this window.
        repeat (LATENCY + 8) @(posedge i_clk);
        if (fail_count == 0)
            $display("[quaternion_smallest_three_decode_top] OK");
        else
            $display("[quaternion_smallest_three_decode_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
